@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned PAY_W   = 16;
  localparam int unsigned ECNT_W  = 5;

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ src/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts it on insert or remove.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  logic               left_keep,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // Held entries at or above the new priority stay ahead of it.
  assign keep  = occ && (entry_r.prio >= ctrl.new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ src/sorted_priority_queue_unit.sv @@
// Sorted priority queue built as a chain of compare-and-shift slots.
// The queue accepts one request per cycle and returns its result in the next
// cycle from an output register; a new request is taken while that result
// waits as long as the result is taken in the same cycle. Every slot compares
// its entry with the broadcast priority in parallel, so an insert or a remove
// updates every slot at once regardless of how many entries are held. Slot 0
// is the head; equal priorities leave in arrival order. Inserts into a full
// queue and removes from an empty one change nothing and report a status.
module sorted_priority_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // new_prio[15:0], new_payload[31:16]
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_prio[15:0], out_payload[31:16],
                                  // entry_count[36:32], zero[39:37]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned D = spq_pkg::DEPTH;
  localparam int unsigned W = spq_pkg::CNT_W;

  logic [W-1:0]        count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [39:0]         out_data_r, out_data_nxt;
  logic [1:0]          out_user_r, out_user_nxt;

  spq_pkg::cell_ctrl_t ctrl;
  logic [D-1:0]        occ;
  logic [D-1:0]        keep;
  spq_pkg::entry_t     entries [D];

  logic                accept;
  logic                is_remove;
  logic                full;
  logic                empty;
  spq_pkg::status_t    status;
  spq_pkg::entry_t     head_out;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_remove = (spq_pkg::req_t'(in_tuser) == spq_pkg::REQ_REMOVE);
  assign full      = (count_r == W'(D));
  assign empty     = (count_r == '0);

  always_comb begin
    for (int i = 0; i < D; i++) begin
      occ[i] = (W'(i) < count_r);
    end
  end

  assign ctrl.ins = accept && !is_remove && !full;
  assign ctrl.rem = accept && is_remove && !empty;
  assign ctrl.new_entry.prio    = in_tdata[15:0];
  assign ctrl.new_entry.payload = in_tdata[31:16];

  for (genvar g = 0; g < D; g++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[g]),
      .left_keep   ((g == 0) ? 1'b1 : keep[(g == 0) ? 0 : g-1]),
      .left_entry  (entries[(g == 0) ? 0 : g-1]),
      .right_entry (entries[(g == D-1) ? D-1 : g+1]),
      .keep        (keep[g]),
      .entry       (entries[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    status    = spq_pkg::ST_DONE;
    head_out  = '0;
    if (is_remove) begin
      if (empty) begin
        status = spq_pkg::ST_EMPTY;
      end else begin
        head_out  = entries[0];
        count_nxt = count_r - W'(1);
      end
    end else begin
      if (full) begin
        status = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, spq_pkg::ECNT_W'(count_nxt),
                       head_out.payload, head_out.prio};
      out_user_nxt  = status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= accept ? count_nxt : count_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ src/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                 && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Stall the input only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // A dropped insert reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::ST_FULL |->
      out_tdata[36:32] == spq_pkg::ECNT_W'(spq_pkg::DEPTH) && out_tdata[31:0] == '0)
    else $error("full status with wrong count or data");

  // A remove on an empty queue reports nothing held and no entry.
  a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::ST_EMPTY |-> out_tdata == '0)
    else $error("empty status with nonzero data or count");

  // An accepted beat yields a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
